FILE: rtl/dce_pkg.sv
// ----------------------------------------------------------------------------
// dce_pkg
// Shared types and constants for the dyadic convolution engine: field widths,
// the controller state encoding and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dce_pkg;

   // Field widths
   localparam int IDX_W       = 4;    // element / result index
   localparam int VAL_W       = 16;   // loaded row element
   localparam int PROD_W      = 2 * VAL_W;
   localparam int RES_W       = 38;   // result element
   localparam int REQ_TDATA_W = 40;   // index + a + b, padded to bytes
   localparam int RSP_TDATA_W = 48;   // index + result, padded to bytes

   // Configuration space
   localparam int         CSR_ADDR_W     = 3;
   localparam int         CSR_DATA_W     = 32;
   localparam int         LOG_SIZE_W     = 3;
   localparam logic [LOG_SIZE_W-1:0] LOG_SIZE_RESET = 3'd4;
   // register index taken from the word address bit
   localparam logic       REG_LOG_SIZE   = 1'b0;

   // Controller states
   typedef enum logic [1:0] {
      ST_LOAD,    // accept element pairs
      ST_ISSUE,   // stream n operand reads for the current output column
      ST_DRAIN,   // let the multiply-accumulate pipe empty
      ST_EMIT     // hand the finished column to the output register
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic rd_en;       // read both row stores this cycle
      logic acc_clear;   // zero the accumulator
      logic emit;        // load the output register with the accumulator
      logic emit_last;   // final column of the row
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic busy;        // reads or products still in flight
      logic out_free;    // output register can take a beat this cycle
   } status_type;

endpackage

FILE: rtl/dce_ram.sv
// ----------------------------------------------------------------------------
// dce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dce_ctrl.sv
// ----------------------------------------------------------------------------
// dce_ctrl
// Sequencer for the dyadic convolution: takes the load phase, then for each
// output column k walks j over the row and issues reads of a[j] and
// b[j xor k], waits for the accumulator and hands each column to the output.
// ----------------------------------------------------------------------------
module dce_ctrl #(
   parameter int MAX_ORDER = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tlast,
   output logic                         req_tready,
   input  logic [dce_pkg::LOG_SIZE_W-1:0] log_size,
   input  dce_pkg::status_type          status,
   output dce_pkg::cmd_type             cmd,
   output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_addr_a,
   output logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_addr_b,
   output logic [dce_pkg::IDX_W-1:0]    emit_index
);

   localparam int AW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   // log2 of the largest power of two not above MAX_ORDER
   localparam int LGMAX = ((1 << $clog2(MAX_ORDER)) == MAX_ORDER) ?
                          $clog2(MAX_ORDER) : $clog2(MAX_ORDER) - 1;
   localparam int CW    = (LGMAX > 0) ? LGMAX : 1;

   dce_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      mask_ff, mask_in;
   logic [dce_pkg::LOG_SIZE_W-1:0] lg_eff;

   // order in use, saturated to what the stores hold
   always_comb begin
      if (log_size > dce_pkg::LOG_SIZE_W'(LGMAX)) begin
         lg_eff = dce_pkg::LOG_SIZE_W'(LGMAX);
      end else begin
         lg_eff = log_size;
      end
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dce_pkg::ST_LOAD;
         j_ff     <= '0;
         k_ff     <= '0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         mask_ff  <= mask_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      mask_in       = mask_ff;
      req_tready    = 1'b0;
      cmd.rd_en     = 1'b0;
      cmd.acc_clear = 1'b0;
      cmd.emit      = 1'b0;
      cmd.emit_last = (k_ff == mask_ff);
      rd_addr_a     = AW'(j_ff);
      rd_addr_b     = AW'(j_ff ^ k_ff);
      emit_index    = dce_pkg::IDX_W'(k_ff);

      case (state_ff)
         dce_pkg::ST_LOAD: begin
            req_tready    = 1'b1;
            cmd.acc_clear = 1'b1;
            j_in          = '0;
            k_in          = '0;
            if (req_tvalid && req_tlast) begin
               mask_in  = CW'((32'd1 << lg_eff) - 32'd1);
               state_in = dce_pkg::ST_ISSUE;
            end
         end
         dce_pkg::ST_ISSUE: begin
            cmd.rd_en = 1'b1;
            if (j_ff == mask_ff) begin
               j_in     = '0;
               state_in = dce_pkg::ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         dce_pkg::ST_DRAIN: begin
            if (!status.busy) begin
               state_in = dce_pkg::ST_EMIT;
            end
         end
         dce_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.acc_clear = 1'b1;
               if (k_ff == mask_ff) begin
                  k_in     = '0;
                  state_in = dce_pkg::ST_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = dce_pkg::ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = dce_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

FILE: rtl/dce_datapath.sv
// ----------------------------------------------------------------------------
// dce_datapath
// Row stores for a and b, one signed multiplier with a product register, the
// column accumulator and the output register of the result stream.
// ----------------------------------------------------------------------------
module dce_datapath #(
   parameter int MAX_ORDER = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // load side
   input  logic                                load_en,
   input  logic [dce_pkg::IDX_W-1:0]           elem_index,
   input  logic signed [dce_pkg::VAL_W-1:0]    a_value,
   input  logic signed [dce_pkg::VAL_W-1:0]    b_value,
   // controller
   input  dce_pkg::cmd_type                    cmd,
   input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_addr_a,
   input  logic [(MAX_ORDER > 1 ? $clog2(MAX_ORDER) : 1)-1:0] rd_addr_b,
   input  logic [dce_pkg::IDX_W-1:0]           emit_index,
   output dce_pkg::status_type                 status,
   // result side
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [dce_pkg::IDX_W-1:0]           rsp_index,
   output logic signed [dce_pkg::RES_W-1:0]    rsp_value,
   output logic                                rsp_last
);

   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int EW = (AW > dce_pkg::IDX_W) ? AW : dce_pkg::IDX_W;

   logic [EW-1:0]                      index_wide;
   logic                               wr_en;
   logic [AW-1:0]                      wr_addr;
   logic signed [dce_pkg::VAL_W-1:0]   a_rd, b_rd;

   logic                               rd_vld_ff, rd_vld_in;
   logic                               prod_vld_ff, prod_vld_in;
   logic signed [dce_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [dce_pkg::RES_W-1:0]   acc_ff, acc_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dce_pkg::IDX_W-1:0]          rsp_index_ff, rsp_index_in;
   logic signed [dce_pkg::RES_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                               rsp_last_ff, rsp_last_in;

   // pairs beyond the stores are dropped
   assign index_wide = EW'(elem_index);
   assign wr_en      = load_en && (32'(elem_index) < 32'(MAX_ORDER));
   assign wr_addr    = index_wide[AW-1:0];

   dce_ram #(
      .WIDTH (dce_pkg::VAL_W),
      .DEPTH (MAX_ORDER)
   ) u_a_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (a_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_a),
      .rd_data (a_rd)
   );

   dce_ram #(
      .WIDTH (dce_pkg::VAL_W),
      .DEPTH (MAX_ORDER)
   ) u_b_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (b_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr_b),
      .rd_data (b_rd)
   );

   // multiply-accumulate pipe: read data -> product -> accumulator
   always_comb begin
      rd_vld_in   = cmd.rd_en;
      prod_vld_in = rd_vld_ff;
      prod_in     = prod_ff;
      if (rd_vld_ff) begin
         prod_in = a_rd * b_rd;
      end
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + dce_pkg::RES_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= rd_vld_in;
         prod_vld_ff <= prod_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // output register; a beat can be replaced in the cycle it is taken
   assign status.busy     = rd_vld_ff || prod_vld_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = emit_index;
         rsp_value_in = acc_ff;
         rsp_last_in  = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

FILE: rtl/dyadic_convolution_engine.sv
// ----------------------------------------------------------------------------
// dyadic_convolution_engine
// First row of the product of two recursively block-symmetric matrices, i.e.
// the dyadic (xor) convolution c[k] = sum_j a[j] * b[j xor k] of loaded rows.
// ----------------------------------------------------------------------------
// Load: one element pair per cycle while idle; the last pair starts the row.
// Compute: one multiply-accumulate per cycle while a column's reads issue; each
//   column is n reads, a drain of the read/multiply pipe and an emit that waits
//   out output stalls, over a row of n = 2^log_size (capped at MAX_ORDER) results.
// Loading of the next row opens as soon as the last column enters the output.
// Reset (synchronous): controller idle, output empty, log_size = 4; the row
//   stores are not cleared and hold whatever was loaded last.
module dyadic_convolution_engine #(
   parameter int MAX_ORDER = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // element pairs in
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dce_pkg::REQ_TDATA_W-1:0]    req_tdata,  // elem_index, a_value, b_value
   input  logic                               req_tlast,  // load_last
   // product row out
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dce_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // result_index, result_value
   output logic                               rsp_tlast,  // result_last
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dce_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dce_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dce_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   logic [dce_pkg::LOG_SIZE_W-1:0] log_size_ff, log_size_in;
   logic                           csr_write;

   dce_pkg::cmd_type               cmd;
   dce_pkg::status_type            status;
   logic [AW-1:0]                  rd_addr_a, rd_addr_b;
   logic [dce_pkg::IDX_W-1:0]      emit_index;
   logic [dce_pkg::IDX_W-1:0]      rsp_index;
   logic signed [dce_pkg::RES_W-1:0] rsp_value;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == dce_pkg::REG_LOG_SIZE);

   always_comb begin
      log_size_in = log_size_ff;
      if (csr_write) begin
         log_size_in = csr_pwdata[dce_pkg::LOG_SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log_size_ff <= dce_pkg::LOG_SIZE_RESET;
      end else begin
         log_size_ff <= log_size_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == dce_pkg::REG_LOG_SIZE) begin
         csr_prdata = dce_pkg::CSR_DATA_W'(log_size_ff);
      end
   end

   dce_ctrl #(
      .MAX_ORDER (MAX_ORDER)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .log_size   (log_size_ff),
      .status     (status),
      .cmd        (cmd),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .emit_index (emit_index)
   );

   dce_datapath #(
      .MAX_ORDER (MAX_ORDER)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .load_en    (req_tvalid && req_tready),
      .elem_index (req_tdata[3:0]),
      .a_value    (req_tdata[19:4]),
      .b_value    (req_tdata[35:20]),
      .cmd        (cmd),
      .rd_addr_a  (rd_addr_a),
      .rd_addr_b  (rd_addr_b),
      .emit_index (emit_index),
      .status     (status),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_index  (rsp_index),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, rsp_value, rsp_index};

   // nothing may be in flight in the multiply pipe while pairs are loaded
   a_idle_while_loading: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !status.busy)
      else $error("multiply pipe active during load phase");

   // the final pair of a row closes the load phase
   a_last_closes_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("load phase still open after final pair");

   // a row in progress keeps loading closed
   a_row_blocks_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("load phase open before row is complete");

endmodule

FILE: dv/dyadic_convolution_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dyadic_convolution_engine_test
// Self-checking bench for the dyadic convolution engine. Element pairs stream
// in, and every beat of the product row is compared with a local mirror of
// the row stores and the xor convolution. A short directed table comes first:
// order one, extreme values, an index past the order, an oversized log_size
// and an order change in mid-load. Random rows follow, mostly complete loads
// with random content, with random gaps on both streams.
// ----------------------------------------------------------------------------
module dyadic_convolution_engine_test;

   localparam int MAX_ORDER     = 16;
   localparam int MAX_LOG       = $clog2(MAX_ORDER);
   localparam int RANDOM_PAIRS  = 350;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 2 * (MAX_ORDER + 4);   // one column, twice over
   localparam int PRINT_CAP     = 200;
   localparam int DIRECTED_ROWS = 27;
   // log_size is register 0, byte address 0
   localparam logic [dce_pkg::CSR_ADDR_W-1:0] LOG_SIZE_ADDR = '0;

   typedef struct {
      logic [dce_pkg::IDX_W-1:0] index;
      logic [dce_pkg::VAL_W-1:0] a;
      logic [dce_pkg::VAL_W-1:0] b;
      bit                        last;
   } pair_type;

   typedef struct packed {
      logic [dce_pkg::IDX_W-1:0] index;
      logic [dce_pkg::RES_W-1:0] value;
      logic                      last;
   } product_beat_type;

   // cfg rows write log_size; known rows carry the value of every product beat
   typedef struct {
      bit                        cfg;
      bit [2:0]                  log_val;
      logic [dce_pkg::IDX_W-1:0] index;
      logic [dce_pkg::VAL_W-1:0] a;
      logic [dce_pkg::VAL_W-1:0] b;
      bit                        last;
      bit                        known;
      longint                    known_val;
   } directed_row_type;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // order of one: single product a[0]*b[0]
      '{1, 3'd0, 4'd0,  16'h0000, 16'h0000, 0, 0, 0},
      '{0, 3'd0, 4'd0,  16'h8000, 16'h8000, 1, 1, 64'sd1073741824},
      '{0, 3'd0, 4'd0,  16'h7FFF, 16'h8000, 1, 1, -64'sd1073709056},
      // order two, with an index past the order that is stored but unused
      '{1, 3'd1, 4'd0,  16'h0000, 16'h0000, 0, 0, 0},
      '{0, 3'd0, 4'd1,  16'd5,    16'd7,    0, 0, 0},
      '{0, 3'd0, 4'd9,  16'd100,  16'hFF9C, 0, 0, 0},
      '{0, 3'd0, 4'd0,  16'd3,    16'hFFFE, 1, 0, 0},
      // oversized log_size saturates to order 16; all extremes
      '{1, 3'd7, 4'd0,  16'h0000, 16'h0000, 0, 0, 0},
      '{0, 3'd0, 4'd0,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd1,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd2,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd3,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd4,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd5,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd6,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd7,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd8,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd9,  16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd10, 16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd11, 16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd12, 16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd13, 16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd14, 16'h8000, 16'h8000, 0, 0, 0},
      '{0, 3'd0, 4'd15, 16'h8000, 16'h8000, 1, 1, 64'sd17179869184},
      // order change in mid-load: the order at the last pair decides
      '{0, 3'd0, 4'd2,  16'h7FFF, 16'h8000, 0, 0, 0},
      '{1, 3'd2, 4'd0,  16'h0000, 16'h0000, 0, 0, 0},
      '{0, 3'd0, 4'd3,  16'h8000, 16'h7FFF, 1, 0, 0}
   };

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [dce_pkg::REQ_TDATA_W-1:0] req_tdata;    // elem_index, a_value, b_value, pad
   logic                            req_tlast;    // load_last
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [dce_pkg::RSP_TDATA_W-1:0] rsp_tdata;    // result_index, result_value, pad
   logic                            rsp_tlast;    // result_last
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [dce_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [dce_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [dce_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   dyadic_convolution_engine #(.MAX_ORDER(MAX_ORDER)) dut (.*);

   // mirror of the block state
   logic signed [dce_pkg::VAL_W-1:0] a_row_copy [MAX_ORDER];
   logic signed [dce_pkg::VAL_W-1:0] b_row_copy [MAX_ORDER];
   bit [MAX_ORDER-1:0]               loaded_mask;
   bit [2:0]                         log_size_copy;

   product_beat_type pending_products [$];
   int               mismatch_count;
   bit               steady;   // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   function automatic int order_now();
      return 1 << ((log_size_copy > MAX_LOG) ? MAX_LOG : log_size_copy);
   endfunction

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [dce_pkg::VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12)
         return 16'h8000;
      if (r < 24)
         return 16'h7FFF;
      if (r < 28)
         return 16'h0000;
      if (r < 32)
         return 16'hFFFF;
      return dce_pkg::VAL_W'($urandom());
   endfunction

   // store one accepted pair; on the last pair convolve the rows and queue
   // the product beats
   function automatic void absorb_pair(input pair_type p, input bit known,
                                       input longint known_val);
      int               n;
      longint           acc;
      product_beat_type beat;
      a_row_copy[p.index] = p.a;
      b_row_copy[p.index] = p.b;
      loaded_mask[p.index] = 1'b1;
      if (!p.last)
         return;
      n = order_now();
      for (int k = 0; k < n; k++) begin
         acc = 0;
         for (int j = 0; j < n; j++)
            acc += longint'(a_row_copy[j]) * longint'(b_row_copy[j ^ k]);
         if (known)
            acc = known_val;
         beat.index = k[dce_pkg::IDX_W-1:0];
         beat.value = acc[dce_pkg::RES_W-1:0];
         beat.last  = (k == n - 1);
         pending_products.push_back(beat);
      end
   endfunction

   task automatic send_pair(input pair_type p, input bit known, input longint known_val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, p.b, p.a, p.index};
      req_tlast  <= p.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_pair(p, known, known_val);
   endtask

   // hold the sender until every product beat is back, then let the block settle
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write log_size, then read it back
   task automatic write_log_size(input bit [2:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LOG_SIZE_ADDR;
      csr_pwdata  <= dce_pkg::CSR_DATA_W'(val);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      log_size_copy = val;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[dce_pkg::LOG_SIZE_W-1:0] !== val)
         report_mismatch($sformatf("log_size read %0d, wrote %0d",
                                   csr_prdata[dce_pkg::LOG_SIZE_W-1:0], val));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side: random stalls, every beat checked against the oldest expectation
   initial begin
      int                        stall;
      product_beat_type          want;
      logic [dce_pkg::IDX_W-1:0] got_index;
      logic [dce_pkg::RES_W-1:0] got_value;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_index = rsp_tdata[0 +: dce_pkg::IDX_W];
            got_value = rsp_tdata[dce_pkg::IDX_W +: dce_pkg::RES_W];
            if (pending_products.size() == 0) begin
               report_mismatch($sformatf("unexpected beat index %0d value %0d",
                                         got_index, $signed(got_value)));
            end else begin
               want = pending_products.pop_front();
               if (got_index !== want.index)
                  report_mismatch($sformatf("result_index %0d, expected %0d",
                                            got_index, want.index));
               if (got_value !== want.value)
                  report_mismatch($sformatf("result_value %0d at index %0d, expected %0d",
                                            $signed(got_value), want.index,
                                            $signed(want.value)));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("result_last %b at index %0d, expected %b",
                                            rsp_tlast, want.index, want.last));
            end
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            stall = pick_gap();
            rsp_tready <= (stall == 0);
         end
      end
   end

   // stimulus
   initial begin
      int        sent;
      int        session;
      int        n;
      int        kind;
      int        count;
      bit        covered;
      int        perm [$];
      pair_type  row_pairs [$];
      pair_type  p;

      mismatch_count = 0;
      steady         = 1'b0;
      loaded_mask    = '0;
      log_size_copy  = dce_pkg::LOG_SIZE_RESET;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg) begin
            quiesce();
            write_log_size(directed_rows[i].log_val);
         end else begin
            p.index = directed_rows[i].index;
            p.a     = directed_rows[i].a;
            p.b     = directed_rows[i].b;
            p.last  = directed_rows[i].last;
            send_pair(p, directed_rows[i].known, directed_rows[i].known_val);
         end
      end

      // random rows; the first eight sessions walk log_size through 0..7
      sent = 0;
      session = 0;
      while (sent < RANDOM_PAIRS) begin
         steady = ($urandom_range(0, 4) == 0);
         if (session < 8 || $urandom_range(0, 5) == 0) begin
            quiesce();
            if (session < 8)
               write_log_size(session[2:0]);
            else if ($urandom_range(0, 99) < 80)
               write_log_size(3'($urandom_range(0, 3)));
            else
               write_log_size(3'($urandom_range(4, 7)));
         end
         n = order_now();
         covered = 1'b1;
         for (int j = 0; j < n; j++)
            if (!loaded_mask[j])
               covered = 1'b0;
         row_pairs.delete();
         kind = $urandom_range(0, 99);
         if (kind < 75 || (!covered && kind < 90)) begin
            // full load in random order, a few stray pairs mixed in
            perm.delete();
            for (int j = 0; j < n; j++)
               perm.push_back(j);
            perm.shuffle();
            foreach (perm[j]) begin
               p.index = dce_pkg::IDX_W'(perm[j]);
               p.a     = pick_value();
               p.b     = pick_value();
               p.last  = 1'b0;
               row_pairs.push_back(p);
            end
            repeat ($urandom_range(0, 2)) begin
               p.index = dce_pkg::IDX_W'($urandom_range(0, MAX_ORDER - 1));
               p.a     = pick_value();
               p.b     = pick_value();
               row_pairs.insert($urandom_range(0, row_pairs.size()), p);
            end
            row_pairs[row_pairs.size() - 1].last = 1'b1;
         end else begin
            // partial update of a covered row, or loose pairs with no last
            count = (kind < 90) ? $urandom_range(1, n) : $urandom_range(1, 4);
            repeat (count) begin
               p.index = dce_pkg::IDX_W'($urandom_range(0, MAX_ORDER - 1));
               p.a     = pick_value();
               p.b     = pick_value();
               p.last  = 1'b0;
               row_pairs.push_back(p);
            end
            if (kind < 90)
               row_pairs[row_pairs.size() - 1].last = 1'b1;
         end
         foreach (row_pairs[j])
            send_pair(row_pairs[j], 1'b0, 0);
         sent += row_pairs.size();
         session++;
         if ($urandom_range(0, 9) == 0)
            quiesce();
      end

      // drain
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: dyadic_convolution_engine.f
rtl/dce_pkg.sv
rtl/dce_ram.sv
rtl/dce_ctrl.sv
rtl/dce_datapath.sv
rtl/dyadic_convolution_engine.sv
dv/dyadic_convolution_engine_test.sv
